// ===== src/dps_pkg.sv =====
// Shared types and constants for the Drucker-Prager strength surface block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dps_pkg;

    // Configuration register indexes.
    localparam logic REG_TENSILE     = 1'b0;
    localparam logic REG_COMPRESSIVE = 1'b1;

    // round(2^32 / sqrt(3)).
    localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700525;

    // Output range of the surface value.
    localparam logic signed [35:0] SURF_MAX = 36'sh7FFFFFFFF;
    localparam logic signed [35:0] SURF_MIN = 36'sh800000000;

    // Control that travels with each word along the pipeline.
    typedef struct packed {
        logic valid;
        logic neg;
    } cell_ctrl_t;

endpackage

// ===== src/dps_front.sv =====
// Front pipeline: invariants, squared deviator sum and the scaled strength term.
// Depends on dps_pkg.
`timescale 1ns / 1ps

module dps_front import dps_pkg::*; #(
    parameter int W = 32,
    localparam int SW = 2 * W + 3,
    localparam int NW = ((W + 34) > 63 ? (W + 34) : 63) + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [W-1:0] s_xx,
    input  logic signed [W-1:0] s_xy,
    input  logic signed [W-1:0] s_xz,
    input  logic signed [W-1:0] s_yx,
    input  logic signed [W-1:0] s_yy,
    input  logic signed [W-1:0] s_yz,
    input  logic signed [W-1:0] s_zx,
    input  logic signed [W-1:0] s_zy,
    input  logic signed [W-1:0] s_zz,
    input  logic [30:0]         tensile,
    input  logic [30:0]         compressive,
    output cell_ctrl_t          ctrl_out,
    input  logic                ready_dn,
    output logic [SW-1:0]       s_out,
    output logic [NW-1:0]       x_out
);

    localparam int PRW = W + 34;
    localparam int HW  = (NW + 1) / 2;
    localparam int LW  = NW - HW;

    // Stage 1: differences, squares, trace product, c*t.
    logic                 v1_reg;
    logic [2*W:0]         sqd_reg [0:2];
    logic [2*W-1:0]       sqo_reg [0:5];
    logic signed [PRW-1:0] pr_reg;
    logic [61:0]          ct_reg;
    logic signed [W:0]    dxy, dyz, dzx;
    logic signed [2*W+1:0] pdxy, pdyz, pdzx;
    logic signed [2*W-1:0] po [0:5];
    logic signed [W+1:0]  i1;
    logic signed [31:0]   cdiff;
    logic signed [PRW-1:0] pr_next;

    // Stage 2: partial sums and the magnitude of N.
    logic                 v2_reg;
    logic [SW-1:0]        psum_reg, qsum_reg;
    logic [NW-1:0]        nmag_reg;
    logic                 neg2_reg;
    logic signed [NW-1:0] n_val;

    // Stage 3: 6*J2 and the two partial products of |N| * K.
    logic                 v3_reg;
    logic [SW-1:0]        s3_reg;
    logic [HW+31:0]       plo_reg;
    logic [LW+31:0]       phi_reg;
    logic                 neg3_reg;

    // Stage 4: |N| * K / 2^32.
    logic                 v4_reg;
    logic [SW-1:0]        s4_reg;
    logic [NW-1:0]        x4_reg;
    logic                 neg4_reg;
    logic [NW+31:0]       xfull;

    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || ready_dn;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        dxy   = (W + 1)'(s_xx) - (W + 1)'(s_yy);
        dyz   = (W + 1)'(s_yy) - (W + 1)'(s_zz);
        dzx   = (W + 1)'(s_zz) - (W + 1)'(s_xx);
        pdxy  = (2 * W + 2)'(dxy) * (2 * W + 2)'(dxy);
        pdyz  = (2 * W + 2)'(dyz) * (2 * W + 2)'(dyz);
        pdzx  = (2 * W + 2)'(dzx) * (2 * W + 2)'(dzx);
        po[0] = (2 * W)'(s_xy) * (2 * W)'(s_xy);
        po[1] = (2 * W)'(s_xz) * (2 * W)'(s_xz);
        po[2] = (2 * W)'(s_yx) * (2 * W)'(s_yx);
        po[3] = (2 * W)'(s_yz) * (2 * W)'(s_yz);
        po[4] = (2 * W)'(s_zx) * (2 * W)'(s_zx);
        po[5] = (2 * W)'(s_zy) * (2 * W)'(s_zy);
        i1    = (W + 2)'(s_xx) + (W + 2)'(s_yy) + (W + 2)'(s_zz);
        cdiff = $signed({1'b0, compressive}) - $signed({1'b0, tensile});
        pr_next = PRW'(cdiff) * PRW'(i1);
    end

    always_comb
    begin
        n_val = NW'(pr_reg) - $signed({{(NW - 63){1'b0}}, ct_reg, 1'b0});
    end

    assign xfull = ({phi_reg, {HW{1'b0}}}) + (NW + 32)'(plo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            sqd_reg[0] <= pdxy[2*W:0];
            sqd_reg[1] <= pdyz[2*W:0];
            sqd_reg[2] <= pdzx[2*W:0];
            for (int k = 0; k < 6; k++)
                sqo_reg[k] <= po[k];
            pr_reg <= pr_next;
            ct_reg <= tensile * compressive;
        end
        if (adv2 && v1_reg)
        begin
            psum_reg <= SW'(sqd_reg[0]) + SW'(sqd_reg[1]) + SW'(sqd_reg[2]);
            qsum_reg <= SW'(sqo_reg[0]) + SW'(sqo_reg[1]) + SW'(sqo_reg[2])
                      + SW'(sqo_reg[3]) + SW'(sqo_reg[4]) + SW'(sqo_reg[5]);
            neg2_reg <= n_val[NW-1];
            nmag_reg <= n_val[NW-1] ? NW'(-n_val) : NW'(n_val);
        end
        if (adv3 && v2_reg)
        begin
            s3_reg   <= psum_reg + (qsum_reg << 1) + qsum_reg;
            plo_reg  <= (HW + 32)'(nmag_reg[HW-1:0]) * (HW + 32)'(INV_SQRT3_Q32);
            phi_reg  <= (LW + 32)'(nmag_reg[NW-1:HW]) * (LW + 32)'(INV_SQRT3_Q32);
            neg3_reg <= neg2_reg;
        end
        if (adv4 && v3_reg)
        begin
            s4_reg   <= s3_reg;
            x4_reg   <= xfull[NW+31:32];
            neg4_reg <= neg3_reg;
        end
    end

    assign ctrl_out.valid = v4_reg;
    assign ctrl_out.neg   = neg4_reg;
    assign s_out          = s4_reg;
    assign x_out          = x4_reg;

endmodule

// ===== src/dps_cell.sv =====
// One root and quotient chain cell: one quotient bit, and a square-root bit when BIT < RW.
// Depends on dps_pkg.
`timescale 1ns / 1ps

module dps_cell import dps_pkg::*; #(
    parameter int W = 32,
    parameter int BIT = 0,
    localparam int SW = 2 * W + 3,
    localparam int RW = W + 1,
    localparam int QW = (W > 32 ? W : 32) + 2,
    localparam int NW = ((W + 34) > 63 ? (W + 34) : 63) + 1,
    localparam int TW = SW + 3,
    localparam int DW = (NW > 32 + QW ? NW : 32 + QW) + 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   d,
    input  cell_ctrl_t    ctrl_in,
    output logic          ready_up,
    input  logic [SW-1:0] srem_in,
    input  logic [RW-1:0] root_in,
    input  logic [NW-1:0] drem_in,
    input  logic [QW-1:0] quo_in,
    output cell_ctrl_t    ctrl_out,
    input  logic          ready_dn,
    output logic [SW-1:0] srem_out,
    output logic [RW-1:0] root_out,
    output logic [NW-1:0] drem_out,
    output logic [QW-1:0] quo_out
);

    localparam bit DO_SQRT = (BIT < RW);

    logic          valid_reg, neg_reg;
    logic [SW-1:0] srem_reg, srem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [NW-1:0] drem_reg, drem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [TW-1:0] tt, trial, srem_ext;
    logic [DW-1:0] dtrial, drem_ext;
    logic          adv;

    assign adv      = !valid_reg || ready_dn;
    assign ready_up = adv;

    // Trying root bit b: 6*(r + 2^b)^2 - 6*r^2 = 6*(r*2^(b+1) + 2^(2b)).
    always_comb
    begin
        tt        = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        trial     = (tt << 2) + (tt << 1);
        srem_ext  = TW'(srem_in);
        srem_next = srem_in;
        root_next = root_in;
        if (DO_SQRT && trial <= srem_ext)
        begin
            srem_next = srem_ext[SW-1:0] - trial[SW-1:0];
            root_next = root_in | (RW'(1) << BIT);
        end
        dtrial    = DW'(d) << BIT;
        drem_ext  = DW'(drem_in);
        drem_next = drem_in;
        quo_next  = quo_in;
        if (dtrial <= drem_ext)
        begin
            drem_next = drem_ext[NW-1:0] - dtrial[NW-1:0];
            quo_next  = quo_in | (QW'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= ctrl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctrl_in.valid)
        begin
            neg_reg  <= ctrl_in.neg;
            srem_reg <= srem_next;
            root_reg <= root_next;
            drem_reg <= drem_next;
            quo_reg  <= quo_next;
        end
    end

    assign ctrl_out.valid = valid_reg;
    assign ctrl_out.neg   = neg_reg;
    assign srem_out       = srem_reg;
    assign root_out       = root_reg;
    assign drem_out       = drem_reg;
    assign quo_out        = quo_reg;

endmodule

// ===== src/drucker_prager_strength_surface.sv =====
// Top level of the Drucker-Prager strength surface block: configuration, cell chain, output.
// Depends on dps_pkg, dps_front and dps_cell.
`timescale 1ns / 1ps

// Usage. One stress tensor word enters on the input channel (in_valid/in_ready, nine
// signed components) and one result word leaves on the output channel
// (out_valid/out_ready, surface_value and saturated). Both are valid/ready handshakes.
// The tensile and compressive strengths are written through cfg_wr_en, cfg_index and
// cfg_data; index 0 is the tensile strength and index 1 the compressive strength.
// They are sampled directly by the pipeline, so the user must write them only while no
// word is in flight; the block itself does not enforce it. Reset sets both strengths to
// 1.0 at FRAC_BITS fractional bits. A word passes four front stages, QW chain cells and
// the output register, where QW is DATA_WIDTH or 32, whichever is larger, plus two.
// Each cell retires one quotient bit, and one root bit where its bit is below
// DATA_WIDTH + 1; unless the receiver stalls, a word enters every cycle, one word per cycle.
// Every stage holds its own valid bit and takes a new word whenever it is empty or
// its neighbor moves on, so bubbles close up. When the receiver stalls, the result
// waits in the output register and the pipeline keeps filling until every stage is
// full; only then does in_ready fall. Reset empties all stages at once.

module drucker_prager_strength_surface import dps_pkg::*; #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] s_xx,
    input  logic signed [DATA_WIDTH-1:0] s_xy,
    input  logic signed [DATA_WIDTH-1:0] s_xz,
    input  logic signed [DATA_WIDTH-1:0] s_yx,
    input  logic signed [DATA_WIDTH-1:0] s_yy,
    input  logic signed [DATA_WIDTH-1:0] s_yz,
    input  logic signed [DATA_WIDTH-1:0] s_zx,
    input  logic signed [DATA_WIDTH-1:0] s_zy,
    input  logic signed [DATA_WIDTH-1:0] s_zz,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [35:0]           surface_value,
    output logic                         saturated,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [30:0]                  cfg_data
);

    localparam int W  = DATA_WIDTH;
    localparam int SW = 2 * W + 3;
    localparam int RW = W + 1;
    localparam int QW = (W > 32 ? W : 32) + 2;
    localparam int NW = ((W + 34) > 63 ? (W + 34) : 63) + 1;
    localparam int NC = QW;
    localparam int FW = QW + 2;

    // Strength registers.
    logic [30:0] tensile_reg, compressive_reg;
    logic [31:0] dsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tensile_reg     <= 31'(32'd1 << FRAC_BITS);
            compressive_reg <= 31'(32'd1 << FRAC_BITS);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TENSILE:     tensile_reg     <= cfg_data;
                REG_COMPRESSIVE: compressive_reg <= cfg_data;
                default:         tensile_reg     <= tensile_reg;
            endcase
        end
    end

    // User rule: the divisor c + t stays constant while words are in flight; not enforced here.
    assign dsum = {1'b0, tensile_reg} + {1'b0, compressive_reg};

    // Links between the front, the cells and the output stage.
    cell_ctrl_t    ctrl_w [0:NC];
    logic          rdy_w  [0:NC];
    logic [SW-1:0] srem_w [0:NC];
    logic [RW-1:0] root_w [0:NC];
    logic [NW-1:0] drem_w [0:NC];
    logic [QW-1:0] quo_w  [0:NC];

    dps_front #(.W(W)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .s_xx        (s_xx),
        .s_xy        (s_xy),
        .s_xz        (s_xz),
        .s_yx        (s_yx),
        .s_yy        (s_yy),
        .s_yz        (s_yz),
        .s_zx        (s_zx),
        .s_zy        (s_zy),
        .s_zz        (s_zz),
        .tensile     (tensile_reg),
        .compressive (compressive_reg),
        .ctrl_out    (ctrl_w[0]),
        .ready_dn    (rdy_w[0]),
        .s_out       (srem_w[0]),
        .x_out       (drem_w[0])
    );

    // The root and quotient start at zero; the cells fill them from the top bit down.
    assign root_w[0] = '0;
    assign quo_w[0]  = '0;

    for (genvar j = 0; j < NC; j++)
    begin : g_cell
        dps_cell #(.W(W), .BIT(NC - 1 - j)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .d        (dsum),
            .ctrl_in  (ctrl_w[j]),
            .ready_up (rdy_w[j]),
            .srem_in  (srem_w[j]),
            .root_in  (root_w[j]),
            .drem_in  (drem_w[j]),
            .quo_in   (quo_w[j]),
            .ctrl_out (ctrl_w[j+1]),
            .ready_dn (rdy_w[j+1]),
            .srem_out (srem_w[j+1]),
            .root_out (root_w[j+1]),
            .drem_out (drem_w[j+1]),
            .quo_out  (quo_w[j+1])
        );
    end

    // Output stage: f = sqrt(J2) +/- B, clipped to 36 bits. With both strengths zero
    // the strength term is defined as zero.
    logic                 out_valid_reg;
    logic signed [35:0]   surface_reg, surface_next;
    logic                 sat_reg, sat_next;
    logic signed [FW-1:0] bterm, fsum;
    logic                 adv_o;

    assign adv_o         = !out_valid_reg || out_ready;
    assign rdy_w[NC]     = adv_o;

    always_comb
    begin
        if (dsum == 32'd0)
            bterm = '0;
        else if (ctrl_w[NC].neg)
            bterm = -$signed(FW'(quo_w[NC]));
        else
            bterm = $signed(FW'(quo_w[NC]));
        fsum = $signed(FW'(root_w[NC])) + bterm;
        if (fsum > FW'(SURF_MAX))
        begin
            surface_next = SURF_MAX;
            sat_next     = 1'b1;
        end
        else if (fsum < FW'(SURF_MIN))
        begin
            surface_next = SURF_MIN;
            sat_next     = 1'b1;
        end
        else
        begin
            surface_next = fsum[35:0];
            sat_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv_o)
            out_valid_reg <= ctrl_w[NC].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv_o && ctrl_w[NC].valid)
        begin
            surface_reg <= surface_next;
            sat_reg     <= sat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign surface_value = surface_reg;
    assign saturated     = sat_reg;

`ifndef SYNTHESIS
    // The input side only backs up once the output word is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while the output was free");

    // A clipped result always sits at one end of the output range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (surface_value == SURF_MAX || surface_value == SURF_MIN))
        else $error("saturated result not at a range limit");

    // A word taken at the output leaves the register empty or refilled, never stale.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !ctrl_w[NC].valid) |=> !out_valid)
        else $error("output word repeated");
`endif

endmodule
